@@ hdl/prap_pkg.sv @@
// Shared constants, tables and types for the pivot rotation pipeline.
package prap_pkg;

  // Datapath widths: offsets carry eight guard fraction bits.
  localparam int unsigned CrdW      = 32;
  localparam int unsigned AngInW    = 18;
  localparam int unsigned GuardBits = 8;
  localparam int unsigned DataW     = 44;
  localparam int unsigned AngW      = 34;

  // Angle reduction: residual angle times 2^21 is divided by 45.
  localparam int unsigned SectorDiv = 45;
  localparam int unsigned FracBits  = 21;
  localparam int unsigned RecipMul  = 1456;
  localparam int unsigned RecipSh   = 16;

  // Inverse CORDIC gain limit in Q0.32.
  localparam logic [31:0] GainQ32 = 32'd2608131496;

  localparam logic signed [CrdW-1:0] CrdMax = {1'b0, {(CrdW-1){1'b1}}};
  localparam logic signed [CrdW-1:0] CrdMin = {1'b1, {(CrdW-1){1'b0}}};

  // atan(2^-i) in 2^32-per-turn units, truncated.
  localparam logic [31:0] AtanTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // Fraction part of the binary angle for each remainder modulo 45.
  typedef logic [FracBits-1:0] frac_tab_t [SectorDiv];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t      tab;
    longint unsigned num;
    for (int r = 0; r < SectorDiv; r++) begin
      num    = (64'(r) << FracBits) + 64'd22;
      tab[r] = FracBits'(num / SectorDiv);
    end
    return tab;
  endfunction

  localparam frac_tab_t FracTab = build_frac_tab();

  // One transaction as it travels down the rotation chain.
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic signed [CrdW-1:0]  cx;
    logic signed [CrdW-1:0]  cy;
  } rot_t;

endpackage

@@ hdl/point_rotate_about_pivot.sv @@
// Throughput: one transaction per cycle while the output is not stalled; every
// stage holds one item and hands it on each cycle unless the next one holds,
// so the chain of micro-rotation cells sets the depth.
// A stall at the output backs up only through occupied stages; gaps fill in.
// Reset clears all valid flags at once; payload registers are not reset.
// Top level of the pivot rotation pipeline.
module point_rotate_about_pivot #(
  parameter int unsigned ITERATIONS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [prap_pkg::CrdW-1:0]   point_x_i,
  input  logic signed [prap_pkg::CrdW-1:0]   point_y_i,
  input  logic signed [prap_pkg::CrdW-1:0]   pivot_x_i,
  input  logic signed [prap_pkg::CrdW-1:0]   pivot_y_i,
  input  logic signed [prap_pkg::AngInW-1:0] turn_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [prap_pkg::CrdW-1:0]   rotated_x_o,
  output logic signed [prap_pkg::CrdW-1:0]   rotated_y_o,
  output logic                               saturated_o
);

  logic           chain_vld   [ITERATIONS+1];
  logic           chain_stall [ITERATIONS+1];
  prap_pkg::rot_t chain_rot   [ITERATIONS+1];

  // Offset and angle preparation.
  prap_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (in_valid_i),
    .stall_o      (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .pivot_x_i    (pivot_x_i),
    .pivot_y_i    (pivot_y_i),
    .turn_angle_i (turn_angle_i),
    .vld_o        (chain_vld[0]),
    .stall_i      (chain_stall[0]),
    .rot_o        (chain_rot[0])
  );

  // Chain of micro-rotation cells.
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    prap_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (chain_vld[g]),
      .stall_o (chain_stall[g]),
      .rot_i   (chain_rot[g]),
      .vld_o   (chain_vld[g+1]),
      .stall_i (chain_stall[g+1]),
      .rot_o   (chain_rot[g+1])
    );
  end

  // Gain compensation and output register.
  prap_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (chain_vld[ITERATIONS]),
    .stall_o     (chain_stall[ITERATIONS]),
    .rot_i       (chain_rot[ITERATIONS]),
    .vld_o       (out_valid_o),
    .stall_i     (out_stall_i),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o),
    .saturated_o (saturated_o)
  );

  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is not held");

  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (rotated_x_o == prap_pkg::CrdMax || rotated_x_o == prap_pkg::CrdMin ||
       rotated_y_o == prap_pkg::CrdMax || rotated_y_o == prap_pkg::CrdMin))
    else $error("saturation flag set without a clamped coordinate");

endmodule

@@ hdl/prap_prep.sv @@
// Front end: pivot offset, angle folding and binary-angle conversion.
module prap_prep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vld_i,
  output logic                                 stall_o,
  input  logic signed [prap_pkg::CrdW-1:0]     point_x_i,
  input  logic signed [prap_pkg::CrdW-1:0]     point_y_i,
  input  logic signed [prap_pkg::CrdW-1:0]     pivot_x_i,
  input  logic signed [prap_pkg::CrdW-1:0]     pivot_y_i,
  input  logic signed [prap_pkg::AngInW-1:0]   turn_angle_i,
  output logic                                 vld_o,
  input  logic                                 stall_i,
  output prap_pkg::rot_t                       rot_o
);

  localparam logic signed [18:0] TurnA    = 19'sd92160;
  localparam logic signed [18:0] HalfA    = 19'sd46080;
  localparam logic signed [18:0] QuarterA = 19'sd23040;
  localparam int unsigned        PadW     = prap_pkg::DataW - 34 - prap_pkg::GuardBits;

  logic [3:0] vld_q;
  logic [3:0] stl;

  // Propagate stall back from the output stage.
  always_comb begin
    stl[3] = vld_q[3] && stall_i;
    stl[2] = vld_q[2] && stl[3];
    stl[1] = vld_q[1] && stl[2];
    stl[0] = vld_q[0] && stl[1];
  end

  assign stall_o = stl[0];
  assign vld_o   = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (!stl[0]) vld_q[0] <= vld_i;
      if (!stl[1]) vld_q[1] <= vld_q[0];
      if (!stl[2]) vld_q[2] <= vld_q[1];
      if (!stl[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Stage A: offsets, fold into one turn, quarter-turn pre-rotation.
  logic signed [33:0] px, py, cx, cy, dx, dy, ndx, ndy, xo, yo;
  logic signed [18:0] a0, a1, a2, amag;
  prap_pkg::rot_t     rot_a_d, rot_a_q;
  logic [14:0]        nmag_a_d, nmag_a_q;
  logic               neg_a_d, neg_a_q;

  always_comb begin
    px  = 34'(point_x_i);
    py  = 34'(point_y_i);
    cx  = 34'(pivot_x_i);
    cy  = 34'(pivot_y_i);
    dx  = px - cx;
    dy  = py - cy;
    ndx = cx - px;
    ndy = cy - py;
    a0  = 19'(turn_angle_i);
    if (a0 >= HalfA) begin
      a1 = a0 - TurnA;
    end else if (a0 < -HalfA) begin
      a1 = a0 + TurnA;
    end else begin
      a1 = a0;
    end
    if (a1 > QuarterA) begin
      xo = ndy;
      yo = dx;
      a2 = a1 - QuarterA;
    end else if (a1 < -QuarterA) begin
      xo = dy;
      yo = ndx;
      a2 = a1 + QuarterA;
    end else begin
      xo = dx;
      yo = dy;
      a2 = a1;
    end
    neg_a_d    = a2[18];
    amag       = neg_a_d ? -a2 : a2;
    nmag_a_d   = amag[14:0];
    rot_a_d.x  = {{PadW{xo[33]}}, xo, {prap_pkg::GuardBits{1'b0}}};
    rot_a_d.y  = {{PadW{yo[33]}}, yo, {prap_pkg::GuardBits{1'b0}}};
    rot_a_d.z  = '0;
    rot_a_d.cx = pivot_x_i;
    rot_a_d.cy = pivot_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && !stl[0]) begin
      rot_a_q  <= rot_a_d;
      nmag_a_q <= nmag_a_d;
      neg_a_q  <= neg_a_d;
    end
  end

  // Stage B: quotient estimate by 45 through a reciprocal multiply.
  logic [25:0]    prod_b;
  logic [9:0]     q0_b_q;
  logic [14:0]    nmag_b_q;
  logic           neg_b_q;
  prap_pkg::rot_t rot_b_q;

  assign prod_b = 26'(nmag_a_q) * 26'(prap_pkg::RecipMul);

  always_ff @(posedge clk_i) begin
    if (vld_q[0] && !stl[1]) begin
      q0_b_q   <= prod_b[prap_pkg::RecipSh +: 10];
      nmag_b_q <= nmag_a_q;
      neg_b_q  <= neg_a_q;
      rot_b_q  <= rot_a_q;
    end
  end

  // Stage C: remainder and one-step quotient correction.
  logic [15:0]    rem_full;
  logic [6:0]     rem0;
  logic [9:0]     q_c_d, q_c_q;
  logic [5:0]     r_c_d, r_c_q;
  logic           neg_c_q;
  prap_pkg::rot_t rot_c_q;

  always_comb begin
    rem_full = 16'(nmag_b_q) - 16'(q0_b_q) * 16'(prap_pkg::SectorDiv);
    rem0     = rem_full[6:0];
    if (rem0 >= 7'(prap_pkg::SectorDiv)) begin
      q_c_d = q0_b_q + 10'd1;
      r_c_d = 6'(rem0 - 7'(prap_pkg::SectorDiv));
    end else begin
      q_c_d = q0_b_q;
      r_c_d = rem0[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[1] && !stl[2]) begin
      q_c_q   <= q_c_d;
      r_c_q   <= r_c_d;
      neg_c_q <= neg_b_q;
      rot_c_q <= rot_b_q;
    end
  end

  // Stage D: assemble the binary angle and restore its sign.
  logic [30:0]                      zmag;
  logic signed [prap_pkg::AngW-1:0] zs;
  prap_pkg::rot_t                   rot_d_d, rot_d_q;

  always_comb begin
    zmag      = {q_c_q, prap_pkg::FracTab[r_c_q]};
    zs        = prap_pkg::AngW'(zmag);
    rot_d_d   = rot_c_q;
    rot_d_d.z = neg_c_q ? -zs : zs;
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[2] && !stl[3]) begin
      rot_d_q <= rot_d_d;
    end
  end

  assign rot_o = rot_d_q;

  a_residual_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> nmag_a_q <= 15'd23040)
    else $error("residual angle exceeds a quarter turn");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> r_c_q < 6'(prap_pkg::SectorDiv))
    else $error("angle remainder not reduced below 45");

endmodule

@@ hdl/prap_cell.sv @@
// One CORDIC micro-rotation cell of the rotation chain.
module prap_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           stall_o,
  input  prap_pkg::rot_t rot_i,
  output logic           vld_o,
  input  logic           stall_i,
  output prap_pkg::rot_t rot_o
);

  localparam logic signed [prap_pkg::AngW-1:0] Atan =
    {{(prap_pkg::AngW-32){1'b0}}, prap_pkg::AtanTab[STAGE]};

  logic                              vld_q;
  logic signed [prap_pkg::DataW-1:0] xs, ys;
  prap_pkg::rot_t                    rot_d, rot_q;

  // Rotate toward zero residual angle.
  always_comb begin
    xs    = rot_i.x >>> STAGE;
    ys    = rot_i.y >>> STAGE;
    rot_d = rot_i;
    if (!rot_i.z[prap_pkg::AngW-1]) begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - Atan;
    end else begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + Atan;
    end
  end

  assign stall_o = vld_q && stall_i;
  assign vld_o   = vld_q;
  assign rot_o   = rot_q;

  // Advance unless the next cell holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!stall_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && !stall_o) begin
      rot_q <= rot_d;
    end
  end

endmodule

@@ hdl/prap_gain.sv @@
// Back end: gain compensation, truncation, pivot re-add and saturation.
module prap_gain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  output logic                             stall_o,
  input  prap_pkg::rot_t                   rot_i,
  output logic                             vld_o,
  input  logic                             stall_i,
  output logic signed [prap_pkg::CrdW-1:0] rotated_x_o,
  output logic signed [prap_pkg::CrdW-1:0] rotated_y_o,
  output logic                             saturated_o
);

  localparam int unsigned DW   = prap_pkg::DataW;
  localparam int unsigned RW   = DW - prap_pkg::GuardBits + 1;
  localparam int unsigned SumW = RW + 2;

  logic [3:0] vld_q;
  logic [3:0] stl;

  // Propagate stall back from the output register.
  always_comb begin
    stl[3] = vld_q[3] && stall_i;
    stl[2] = vld_q[2] && stl[3];
    stl[1] = vld_q[1] && stl[2];
    stl[0] = vld_q[0] && stl[1];
  end

  assign stall_o = stl[0];
  assign vld_o   = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (!stl[0]) vld_q[0] <= vld_i;
      if (!stl[1]) vld_q[1] <= vld_q[0];
      if (!stl[2]) vld_q[2] <= vld_q[1];
      if (!stl[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Stage 1: split into magnitude and sign.
  logic [DW-1:0]                    mag_x_q, mag_y_q;
  logic                             sx1_q, sy1_q;
  logic signed [prap_pkg::CrdW-1:0] cx1_q, cy1_q;

  always_ff @(posedge clk_i) begin
    if (vld_i && !stl[0]) begin
      mag_x_q <= rot_i.x[DW-1] ? DW'(-rot_i.x) : DW'(rot_i.x);
      mag_y_q <= rot_i.y[DW-1] ? DW'(-rot_i.y) : DW'(rot_i.y);
      sx1_q   <= rot_i.x[DW-1];
      sy1_q   <= rot_i.y[DW-1];
      cx1_q   <= rot_i.cx;
      cy1_q   <= rot_i.cy;
    end
  end

  // Stage 2: partial products of magnitude times gain.
  logic [63:0]                      lok_x, lok_y;
  logic [DW-1:0]                    hik_x, hik_y, hik_x_q, hik_y_q;
  logic [31:0]                      lok_x_q, lok_y_q;
  logic                             sx2_q, sy2_q;
  logic signed [prap_pkg::CrdW-1:0] cx2_q, cy2_q;

  assign lok_x = 64'(mag_x_q[31:0]) * 64'(prap_pkg::GainQ32);
  assign lok_y = 64'(mag_y_q[31:0]) * 64'(prap_pkg::GainQ32);
  assign hik_x = DW'(mag_x_q[DW-1:32]) * DW'(prap_pkg::GainQ32);
  assign hik_y = DW'(mag_y_q[DW-1:32]) * DW'(prap_pkg::GainQ32);

  always_ff @(posedge clk_i) begin
    if (vld_q[0] && !stl[1]) begin
      lok_x_q <= lok_x[63:32];
      lok_y_q <= lok_y[63:32];
      hik_x_q <= hik_x;
      hik_y_q <= hik_y;
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
    end
  end

  // Stage 3: sum the products and drop the fraction bits.
  logic [DW:0]                      t_x, t_y;
  logic [RW-1:0]                    r_x_q, r_y_q;
  logic                             sx3_q, sy3_q;
  logic signed [prap_pkg::CrdW-1:0] cx3_q, cy3_q;

  assign t_x = (DW+1)'(hik_x_q) + (DW+1)'(lok_x_q);
  assign t_y = (DW+1)'(hik_y_q) + (DW+1)'(lok_y_q);

  always_ff @(posedge clk_i) begin
    if (vld_q[1] && !stl[2]) begin
      r_x_q <= t_x[DW:prap_pkg::GuardBits];
      r_y_q <= t_y[DW:prap_pkg::GuardBits];
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;
    end
  end

  // Stage 4: re-add the pivot with the sign applied, then clamp.
  logic signed [SumW-1:0]           v_x, v_y, rx_e, ry_e, cx_e, cy_e;
  logic signed [prap_pkg::CrdW-1:0] out_x_d, out_y_d;
  logic                             sat_d;

  always_comb begin
    cx_e = SumW'(cx3_q);
    cy_e = SumW'(cy3_q);
    rx_e = signed'(SumW'(r_x_q));
    ry_e = signed'(SumW'(r_y_q));
    v_x  = sx3_q ? cx_e - rx_e : cx_e + rx_e;
    v_y  = sy3_q ? cy_e - ry_e : cy_e + ry_e;
    sat_d = 1'b0;
    if (v_x > SumW'(prap_pkg::CrdMax)) begin
      out_x_d = prap_pkg::CrdMax;
      sat_d   = 1'b1;
    end else if (v_x < SumW'(prap_pkg::CrdMin)) begin
      out_x_d = prap_pkg::CrdMin;
      sat_d   = 1'b1;
    end else begin
      out_x_d = v_x[prap_pkg::CrdW-1:0];
    end
    if (v_y > SumW'(prap_pkg::CrdMax)) begin
      out_y_d = prap_pkg::CrdMax;
      sat_d   = 1'b1;
    end else if (v_y < SumW'(prap_pkg::CrdMin)) begin
      out_y_d = prap_pkg::CrdMin;
      sat_d   = 1'b1;
    end else begin
      out_y_d = v_y[prap_pkg::CrdW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[2] && !stl[3]) begin
      rotated_x_o <= out_x_d;
      rotated_y_o <= out_y_d;
      saturated_o <= sat_d;
    end
  end

endmodule
